// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker module.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CHK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Overlapping implication checked outside reset.
`define CHK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/trdv_pkg.sv
// Package for the tagged row decoder: codes, phase type and result record.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package trdv_pkg;

    localparam logic [15:0] MAX_VALUES_RESET = 16'd256;

    localparam logic [7:0] TAG_NULL = 8'd0;
    localparam logic [7:0] TAG_BOOL = 8'd1;
    localparam logic [7:0] TAG_INT  = 8'd2;
    localparam logic [7:0] TAG_REAL = 8'd3;
    localparam logic [7:0] TAG_TEXT = 8'd4;

    localparam logic [2:0] KIND_NULL = 3'd0;
    localparam logic [2:0] KIND_BOOL = 3'd1;
    localparam logic [2:0] KIND_TEXT = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNC     = 3'd1;
    localparam logic [2:0] ST_BAD_TAG   = 3'd2;
    localparam logic [2:0] ST_BAD_BOOL  = 3'd3;
    localparam logic [2:0] ST_TOO_MANY  = 3'd4;
    localparam logic [2:0] ST_TRAILING  = 3'd5;

    localparam logic [2:0] SCALAR_LAST = 3'd7;
    localparam logic [2:0] TLEN_LAST   = 3'd3;

    typedef enum logic [7:0] {
        PH_CNT_LO = 8'b0000_0001,
        PH_CNT_HI = 8'b0000_0010,
        PH_TAG    = 8'b0000_0100,
        PH_BOOL   = 8'b0000_1000,
        PH_SCALAR = 8'b0001_0000,
        PH_TLEN   = 8'b0010_0000,
        PH_TBODY  = 8'b0100_0000,
        PH_END    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic        value_valid;
        logic [2:0]  value_kind;
        logic [63:0] value_bits;
        logic        text_valid;
        logic [7:0]  text_char;
        logic        row_done;
        logic [2:0]  status;
    } res_t;

    typedef struct packed {
        logic push;
        res_t data;
    } push_t;

endpackage

`default_nettype wire

// File: rtl/trdv_fifo.sv
// Two-entry result queue between the decoder front and the output stage.
// Depends on trdv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trdv_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire trdv_pkg::push_t wr,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output trdv_pkg::res_t      head
);

    trdv_pkg::res_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        case ({wr.push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            mem_reg[wr_ptr_reg] <= wr.data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/trdv_front.sv
// Decoder front: walks the row format one byte per beat and builds results.
// Depends on trdv_pkg; feeds trdv_fifo.
`timescale 1ns / 1ps
`default_nettype none

module trdv_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      data_byte,
    input  wire logic            final_byte,
    input  wire logic [15:0]     max_values,
    output trdv_pkg::push_t      wr
);

    trdv_pkg::phase_t phase_reg, phase_next;
    logic [15:0] values_left_reg, values_left_next;
    logic [2:0]  kind_reg, kind_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] text_left_reg, text_left_next;
    logic [63:0] asm_reg, asm_next;
    logic        discard_reg, discard_next;

    logic [15:0] cnt;
    logic [2:0]  err;
    logic        value_end;
    trdv_pkg::res_t res;

    always_comb
    begin
        phase_next       = phase_reg;
        values_left_next = values_left_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        text_left_next   = text_left_reg;
        asm_next         = asm_reg;
        discard_next     = discard_reg;
        cnt              = {data_byte, asm_reg[7:0]};
        err              = trdv_pkg::ST_OK;
        value_end        = 1'b0;
        res              = '0;

        if (discard_reg)
        begin
            if (final_byte)
            begin
                phase_next   = trdv_pkg::PH_CNT_LO;
                discard_next = 1'b0;
            end
        end
        else
        begin
            unique case (phase_reg)
                trdv_pkg::PH_CNT_LO:
                begin
                    asm_next[7:0] = data_byte;
                    phase_next    = trdv_pkg::PH_CNT_HI;
                end
                trdv_pkg::PH_CNT_HI:
                begin
                    if (cnt > max_values)
                    begin
                        err = trdv_pkg::ST_TOO_MANY;
                    end
                    else
                    begin
                        values_left_next = cnt;
                        phase_next = (cnt == 16'd0) ? trdv_pkg::PH_END : trdv_pkg::PH_TAG;
                    end
                end
                trdv_pkg::PH_TAG:
                begin
                    idx_next = 3'd0;
                    unique case (data_byte) inside
                        trdv_pkg::TAG_NULL:
                        begin
                            res.value_valid = 1'b1;
                            res.value_kind  = trdv_pkg::KIND_NULL;
                            value_end       = 1'b1;
                        end
                        trdv_pkg::TAG_BOOL:
                        begin
                            phase_next = trdv_pkg::PH_BOOL;
                        end
                        trdv_pkg::TAG_INT, trdv_pkg::TAG_REAL:
                        begin
                            kind_next  = data_byte[2:0];
                            phase_next = trdv_pkg::PH_SCALAR;
                        end
                        trdv_pkg::TAG_TEXT:
                        begin
                            phase_next = trdv_pkg::PH_TLEN;
                        end
                        default:
                        begin
                            err = trdv_pkg::ST_BAD_TAG;
                        end
                    endcase
                end
                trdv_pkg::PH_BOOL:
                begin
                    if (data_byte[7:1] != 7'd0)
                    begin
                        err = trdv_pkg::ST_BAD_BOOL;
                    end
                    else
                    begin
                        res.value_valid = 1'b1;
                        res.value_kind  = trdv_pkg::KIND_BOOL;
                        res.value_bits  = {63'd0, data_byte[0]};
                        value_end       = 1'b1;
                    end
                end
                trdv_pkg::PH_SCALAR:
                begin
                    asm_next[{idx_reg, 3'b000} +: 8] = data_byte;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == trdv_pkg::SCALAR_LAST)
                    begin
                        res.value_valid = 1'b1;
                        res.value_kind  = kind_reg;
                        res.value_bits  = asm_next;
                        value_end       = 1'b1;
                    end
                end
                trdv_pkg::PH_TLEN:
                begin
                    asm_next[{idx_reg, 3'b000} +: 8] = data_byte;
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == trdv_pkg::TLEN_LAST)
                    begin
                        res.value_valid = 1'b1;
                        res.value_kind  = trdv_pkg::KIND_TEXT;
                        res.value_bits  = {32'd0, asm_next[31:0]};
                        text_left_next  = asm_next[31:0];
                        if (asm_next[31:0] == 32'd0)
                        begin
                            value_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = trdv_pkg::PH_TBODY;
                        end
                    end
                end
                trdv_pkg::PH_TBODY:
                begin
                    res.text_valid = 1'b1;
                    res.text_char  = data_byte;
                    text_left_next = text_left_reg - 32'd1;
                    if (text_left_reg == 32'd1)
                    begin
                        value_end = 1'b1;
                    end
                end
                trdv_pkg::PH_END:
                begin
                    err = trdv_pkg::ST_TRAILING;
                end
                default:
                begin
                    phase_next = trdv_pkg::PH_CNT_LO;
                end
            endcase

            if (value_end)
            begin
                values_left_next = values_left_reg - 16'd1;
                phase_next = (values_left_reg == 16'd1) ? trdv_pkg::PH_END : trdv_pkg::PH_TAG;
            end

            if (err != trdv_pkg::ST_OK)
            begin
                res          = '0;
                res.row_done = 1'b1;
                res.status   = err;
                if (final_byte)
                begin
                    phase_next = trdv_pkg::PH_CNT_LO;
                end
                else
                begin
                    discard_next = 1'b1;
                end
            end
            else if (final_byte)
            begin
                res.row_done = 1'b1;
                res.status   = (phase_next == trdv_pkg::PH_END) ? trdv_pkg::ST_OK
                                                                 : trdv_pkg::ST_TRUNC;
                phase_next   = trdv_pkg::PH_CNT_LO;
            end
        end
    end

    assign wr.push = accept && (res.value_valid || res.text_valid || res.row_done);
    assign wr.data = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= trdv_pkg::PH_CNT_LO;
            values_left_reg <= 16'd0;
            kind_reg        <= 3'd0;
            idx_reg         <= 3'd0;
            text_left_reg   <= 32'd0;
            discard_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            values_left_reg <= values_left_next;
            kind_reg        <= kind_next;
            idx_reg         <= idx_next;
            text_left_reg   <= text_left_next;
            discard_reg     <= discard_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            asm_reg <= asm_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/trdv_back.sv
// Output stage: pops results from the queue into a registered stream beat.
// Depends on trdv_pkg; reads trdv_fifo.
`timescale 1ns / 1ps
`default_nettype none

module trdv_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           empty,
    input  wire trdv_pkg::res_t head,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [79:0]         m_tdata,
    output logic [4:0]          m_tuser,
    output logic                m_tlast
);

    logic           valid_reg;
    trdv_pkg::res_t out_reg;

    assign pop = !empty && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || m_tready)
        begin
            valid_reg <= !empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= head;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, out_reg.status, out_reg.text_char, out_reg.value_bits};
    assign m_tuser  = {out_reg.text_valid, out_reg.value_kind, out_reg.value_valid};
    assign m_tlast  = out_reg.row_done;

endmodule

`default_nettype wire

// File: rtl/tagged_row_decoder_validator_unit.sv
// Top level of the tagged row decoder and validator.
// Depends on trdv_pkg, trdv_front, trdv_fifo and trdv_back.
//
// Usage:
//   s_axis: one row byte per beat, tdata[7:0] the byte, tlast on the row's last byte.
//   m_axis: at most one result beat per input beat. tuser flags value_valid,
//     value_kind and text_valid; tdata carries value bits, text byte and status;
//     tlast marks row end (status valid then: ok, truncated, bad tag, bad
//     boolean, too many values, trailing bytes).
//   cfg: write max_values (16 bit); cfg_ready is always high. Write only
//     while no row bytes are in flight.
// Path: each result is written into the queue, then registered in the output stage for m_axis.
// Throughput: one byte per cycle unless s_tready is low; the decoder updates its state
//   on each accepted byte, and a two-entry queue plus the output register absorb a stall.
// Reset: decoder waits for a count byte, queue and output empty,
//   max_values is 256.
// Stall: when m_tready is low the output holds; once the queue fills,
//   s_tready drops until the receiver takes a beat.
`timescale 1ns / 1ps
`default_nettype none

module tagged_row_decoder_validator_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // final_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // value_bits, text_char, status, zero pad
    output logic [4:0]       m_tuser,   // value_valid, value_kind, text_valid
    output logic             m_tlast,   // row_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data   // max_values
);

    logic [15:0]     max_values_reg;
    logic            accept;
    logic            full;
    logic            empty;
    logic            pop;
    trdv_pkg::push_t wr;
    trdv_pkg::res_t  head;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign accept    = s_tvalid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_values_reg <= trdv_pkg::MAX_VALUES_RESET;
        end
        else if (cfg_valid)
        begin
            max_values_reg <= cfg_data;
        end
    end

    trdv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_tdata),
        .final_byte (s_tlast),
        .max_values (max_values_reg),
        .wr         (wr)
    );

    trdv_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .head  (head)
    );

    trdv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/trdv_checker.sv
// Port-level checks for the tagged row decoder, bound to the top level.
// Depends on assert_macros.svh and trdv_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module trdv_assert (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic [4:0]  m_tuser,
    input wire logic        m_tlast
);

    `CHK_NEXT(a_out_hold, m_tvalid && !m_tready,
              m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `CHK_ASSERT(a_one_kind, !(m_tvalid && m_tuser[0] && m_tuser[4]))
    `CHK_IMPLY(a_status_on_end, m_tvalid && !m_tlast, m_tdata[74:72] == trdv_pkg::ST_OK)
    `CHK_IMPLY(a_error_bare, m_tvalid && m_tdata[74:72] != trdv_pkg::ST_OK && m_tdata[74:72] != trdv_pkg::ST_TRUNC,
               m_tuser == 5'd0 && m_tdata[71:0] == 72'd0)
    `CHK_IMPLY(a_no_value_zero, m_tvalid && !m_tuser[0],
               m_tuser[3:1] == 3'd0 && m_tdata[63:0] == 64'd0)

endmodule

bind tagged_row_decoder_validator_unit trdv_assert u_trdv_assert (.*);

`default_nettype wire

// File: test/trdv_checker.sv
// Result checker for tagged_row_decoder_validator_unit: watches cfg, s_axis and m_axis,
// decodes every accepted row byte itself and compares each result beat in order.
// Depends on trdv_pkg.
`timescale 1ns / 1ps

module trdv_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [4:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          mismatch_count,
    output int          outstanding
);

    trdv_pkg::phase_t row_phase;
    logic [15:0]      max_values;
    logic [15:0]      values_left;
    logic [2:0]       cur_tag;
    logic [31:0]      bytes_left;
    logic [63:0]      assembly;
    logic             discarding;
    int               errors;
    trdv_pkg::res_t   expected_results[$];

    task automatic restart_row();
        row_phase   = trdv_pkg::PH_CNT_LO;
        values_left = '0;
        cur_tag     = '0;
        bytes_left  = '0;
        assembly    = '0;
        discarding  = 1'b0;
    endtask

    task automatic finish_value();
        values_left = values_left - 16'd1;
        row_phase   = (values_left == 16'd0) ? trdv_pkg::PH_END : trdv_pkg::PH_TAG;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic fin);
        trdv_pkg::res_t r;
        logic           have;
        logic [2:0]     err;
        logic [15:0]    cnt;
        r    = '0;
        have = 1'b0;
        err  = trdv_pkg::ST_OK;
        if (discarding)
        begin
            if (fin)
                restart_row();
            return;
        end
        case (row_phase)
            trdv_pkg::PH_CNT_LO:
            begin
                assembly  = {56'd0, b};
                row_phase = trdv_pkg::PH_CNT_HI;
            end
            trdv_pkg::PH_CNT_HI:
            begin
                cnt      = {b, assembly[7:0]};
                assembly = '0;
                if (cnt > max_values)
                    err = trdv_pkg::ST_TOO_MANY;
                else
                begin
                    values_left = cnt;
                    row_phase   = (cnt == 16'd0) ? trdv_pkg::PH_END : trdv_pkg::PH_TAG;
                end
            end
            trdv_pkg::PH_TAG:
            begin
                if (b == trdv_pkg::TAG_NULL)
                begin
                    have          = 1'b1;
                    r.value_valid = 1'b1;
                    r.value_kind  = trdv_pkg::KIND_NULL;
                    finish_value();
                end
                else if (b == trdv_pkg::TAG_BOOL)
                begin
                    cur_tag   = trdv_pkg::KIND_BOOL;
                    row_phase = trdv_pkg::PH_BOOL;
                end
                else if (b == trdv_pkg::TAG_INT || b == trdv_pkg::TAG_REAL)
                begin
                    cur_tag    = b[2:0];
                    bytes_left = 32'd8;
                    assembly   = '0;
                    row_phase  = trdv_pkg::PH_SCALAR;
                end
                else if (b == trdv_pkg::TAG_TEXT)
                begin
                    cur_tag    = trdv_pkg::KIND_TEXT;
                    bytes_left = 32'd4;
                    assembly   = '0;
                    row_phase  = trdv_pkg::PH_TLEN;
                end
                else
                    err = trdv_pkg::ST_BAD_TAG;
            end
            trdv_pkg::PH_BOOL:
            begin
                if (b > 8'd1)
                    err = trdv_pkg::ST_BAD_BOOL;
                else
                begin
                    have          = 1'b1;
                    r.value_valid = 1'b1;
                    r.value_kind  = trdv_pkg::KIND_BOOL;
                    r.value_bits  = {63'd0, b[0]};
                    finish_value();
                end
            end
            trdv_pkg::PH_SCALAR:
            begin
                assembly   = assembly | ({56'd0, b} << ((32'd8 - bytes_left) * 8));
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0)
                begin
                    have          = 1'b1;
                    r.value_valid = 1'b1;
                    r.value_kind  = cur_tag;
                    r.value_bits  = assembly;
                    assembly      = '0;
                    finish_value();
                end
            end
            trdv_pkg::PH_TLEN:
            begin
                assembly   = assembly | ({56'd0, b} << ((32'd4 - bytes_left) * 8));
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0)
                begin
                    have          = 1'b1;
                    r.value_valid = 1'b1;
                    r.value_kind  = trdv_pkg::KIND_TEXT;
                    r.value_bits  = {32'd0, assembly[31:0]};
                    bytes_left    = assembly[31:0];
                    assembly      = '0;
                    if (bytes_left == 32'd0)
                        finish_value();
                    else
                        row_phase = trdv_pkg::PH_TBODY;
                end
            end
            trdv_pkg::PH_TBODY:
            begin
                have         = 1'b1;
                r.text_valid = 1'b1;
                r.text_char  = b;
                if (bytes_left > 32'd0)
                    bytes_left = bytes_left - 32'd1;
                if (bytes_left == 32'd0)
                    finish_value();
            end
            default:
                err = trdv_pkg::ST_TRAILING;
        endcase
        if (err != trdv_pkg::ST_OK)
        begin
            r          = '0;
            r.row_done = 1'b1;
            r.status   = err;
            have       = 1'b1;
            if (fin)
                restart_row();
            else
                discarding = 1'b1;
        end
        else if (fin)
        begin
            have       = 1'b1;
            r.row_done = 1'b1;
            r.status   = (row_phase == trdv_pkg::PH_END) ? trdv_pkg::ST_OK : trdv_pkg::ST_TRUNC;
            restart_row();
        end
        if (have)
            expected_results.insert(expected_results.size(), r);
    endtask

    task automatic report_fault(input string what, input trdv_pkg::res_t want,
                                input trdv_pkg::res_t got);
        errors = errors + 1;
        if (errors <= 10)
        begin
            $display("%s: expected vv=%0d kind=%0d bits=%h tv=%0d ch=%h done=%0d st=%0d",
                     what, want.value_valid, want.value_kind, want.value_bits,
                     want.text_valid, want.text_char, want.row_done, want.status);
            $display("    actual vv=%0d kind=%0d bits=%h tv=%0d ch=%h done=%0d st=%0d pad=%h",
                     got.value_valid, got.value_kind, got.value_bits, got.text_valid,
                     got.text_char, got.row_done, got.status, m_tdata[79:75]);
        end
    endtask

    task automatic check_result();
        trdv_pkg::res_t got;
        trdv_pkg::res_t want;
        got.value_valid = m_tuser[0];
        got.value_kind  = m_tuser[3:1];
        got.text_valid  = m_tuser[4];
        got.value_bits  = m_tdata[63:0];
        got.text_char   = m_tdata[71:64];
        got.status      = m_tdata[74:72];
        got.row_done    = m_tlast;
        if (expected_results.size() == 0)
        begin
            want = '0;
            report_fault("unexpected beat", want, got);
        end
        else
        begin
            want = expected_results.pop_front();
            if (got !== want || m_tdata[79:75] !== 5'd0)
                report_fault("mismatch", want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_row();
            max_values = trdv_pkg::MAX_VALUES_RESET;
            errors     = 0;
            expected_results.delete();
            mismatch_count <= 0;
            outstanding    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_values = cfg_data;
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            mismatch_count <= errors;
            outstanding    <= expected_results.size();
        end
    end

endmodule

// File: test/tagged_row_decoder_validator_unit_tb.sv
// Testbench top for tagged_row_decoder_validator_unit: directed and random rows,
// random stalls on both streams, max_values changes between phases.
// Depends on trdv_pkg, trdv_checker and the block itself.
`timescale 1ns / 1ps

module tagged_row_decoder_validator_unit_tb;

    typedef enum int {
        ROW_GOOD,
        ROW_TRUNC,
        ROW_BAD_TAG,
        ROW_BAD_BOOL,
        ROW_TRAIL,
        ROW_OVER,
        ROW_NOISE
    } row_kind_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = 16'd0;

    int          mismatch_count;
    int          outstanding;
    int          send_idle = 10;
    int          recv_idle = 45;
    logic [15:0] cur_max   = trdv_pkg::MAX_VALUES_RESET;
    logic [7:0]  row_bytes[$];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    tagged_row_decoder_validator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    trdv_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        else
            m_tready <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_row();
        int i;
        for (i = 0; i < row_bytes.size(); i++)
            send_byte(row_bytes[i], i == row_bytes.size() - 1);
    endtask

    // lets every result drain; discarded bytes give none, so it keeps idling after the last expected result
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_max = v;
    endtask

    task automatic add_byte(input logic [7:0] b);
        row_bytes.insert(row_bytes.size(), b);
    endtask

    task automatic push_le(input logic [31:0] v, input int nbytes);
        int i;
        for (i = 0; i < nbytes; i++)
            add_byte(v[8*i +: 8]);
    endtask

    task automatic build_random_row();
        row_kind_t   kind;
        int          r;
        int          n;
        int          gen;
        int          err_at;
        int          k;
        int          i;
        int          cut;
        int          c;
        logic [7:0]  tag;
        logic [31:0] tl;
        row_bytes.delete();
        r = $urandom_range(0, 99);
        if (r < 55)
            kind = ROW_GOOD;
        else if (r < 65)
            kind = ROW_TRUNC;
        else if (r < 72)
            kind = ROW_BAD_TAG;
        else if (r < 79)
            kind = ROW_BAD_BOOL;
        else if (r < 86)
            kind = ROW_TRAIL;
        else if (r < 93)
            kind = ROW_OVER;
        else
            kind = ROW_NOISE;
        if (kind == ROW_OVER && cur_max == 16'hFFFF)
            kind = ROW_GOOD;
        if ((kind == ROW_BAD_TAG || kind == ROW_BAD_BOOL) && cur_max == 16'd0)
            kind = ROW_NOISE;

        if (kind == ROW_NOISE)
        begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                add_byte(8'($urandom_range(0, 255)));
            return;
        end
        if (kind == ROW_OVER)
        begin
            c = int'(cur_max) + 1 + int'($urandom_range(0, 65534 - int'(cur_max)));
            push_le(c, 2);
            if ($urandom_range(0, 1) == 1)
            begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++)
                    add_byte(8'($urandom_range(0, 255)));
            end
            return;
        end

        n = $urandom_range(0, 5);
        if (n > cur_max)
            n = cur_max;
        if ((kind == ROW_BAD_TAG || kind == ROW_BAD_BOOL) && n == 0)
            n = 1;
        gen = n;
        if (kind == ROW_TRUNC && cur_max > 0 && $urandom_range(0, 3) == 0)
        begin
            n   = $urandom_range(1, cur_max);
            gen = (n > 6) ? 6 : n;
        end
        if (kind == ROW_BAD_TAG || kind == ROW_BAD_BOOL)
            err_at = int'($urandom_range(0, n - 1));
        else
            err_at = -1;
        push_le(n, 2);

        for (k = 0; k < gen; k++)
        begin
            if (k == err_at)
            begin
                if (kind == ROW_BAD_TAG)
                    add_byte(8'($urandom_range(5, 255)));
                else
                begin
                    add_byte(trdv_pkg::TAG_BOOL);
                    add_byte(8'($urandom_range(2, 255)));
                end
                if ($urandom_range(0, 1) == 1)
                    return;
            end
            tag = 8'($urandom_range(0, 4));
            add_byte(tag);
            if (tag == trdv_pkg::TAG_BOOL)
                add_byte(8'($urandom_range(0, 1)));
            else if (tag == trdv_pkg::TAG_INT || tag == trdv_pkg::TAG_REAL)
            begin
                for (i = 0; i < 8; i++)
                    add_byte(8'($urandom_range(0, 255)));
            end
            else if (tag == trdv_pkg::TAG_TEXT)
            begin
                if (kind == ROW_TRUNC && $urandom_range(0, 3) == 0)
                begin
                    // long text header, row ends inside the body
                    tl = $urandom;
                    push_le(tl, 4);
                    n = $urandom_range(0, 3);
                    for (i = 0; i < n; i++)
                        add_byte(8'($urandom_range(0, 255)));
                    return;
                end
                tl = $urandom_range(0, 4);
                push_le(tl, 4);
                for (i = 0; i < tl; i++)
                    add_byte(8'($urandom_range(0, 255)));
            end
        end

        if (kind == ROW_TRAIL)
        begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                add_byte(8'($urandom_range(0, 255)));
        end
        if (kind == ROW_TRUNC && gen == n && row_bytes.size() > 1)
        begin
            cut = $urandom_range(1, row_bytes.size() - 1);
            row_bytes = row_bytes[0:cut-1];
        end
    endtask

    task automatic run_phase(input int nbytes);
        int sent;
        sent = 0;
        while (sent < nbytes)
        begin
            build_random_row();
            send_row();
            sent += row_bytes.size();
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // null, boolean, empty text, row complete on the final byte
        row_bytes = '{8'h03, 8'h00, trdv_pkg::TAG_NULL, trdv_pkg::TAG_BOOL, 8'h01,
                      trdv_pkg::TAG_TEXT, 8'h00, 8'h00, 8'h00, 8'h00};
        send_row();
        // all-ones real, then a trailing byte that is also the final byte
        row_bytes = '{8'h01, 8'h00, trdv_pkg::TAG_REAL, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_row();
        // count above the limit, rest of row dropped
        row_bytes = '{8'hFF, 8'hFF, 8'h00};
        send_row();
        // bad tag and bad boolean on the final byte
        row_bytes = '{8'h01, 8'h00, 8'h05};
        send_row();
        row_bytes = '{8'h01, 8'h00, trdv_pkg::TAG_BOOL, 8'h02};
        send_row();
        // truncated rows
        row_bytes = '{8'h01, 8'h00, trdv_pkg::TAG_INT};
        send_row();
        row_bytes = '{8'h00};
        send_row();

        wait_idle();
        write_cfg(16'hFFFF);
        run_phase(520);

        wait_idle();
        write_cfg(16'h0000);
        run_phase(30);

        wait_idle();
        write_cfg(16'($urandom_range(1, 6)));
        send_idle = 45;
        recv_idle = 10;
        run_phase(520);

        wait_idle();
        write_cfg(16'($urandom_range(2, 5)));
        send_idle = 0;
        recv_idle = 0;
        run_phase(520);

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
